// ===== rtl/sbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

   // Field and storage widths
   localparam int COORD_W     = 12;
   localparam int ROI_W       = COORD_W + 1;
   localparam int DISP_W      = 16;
   localparam int DISP_FRAC   = 4;
   localparam int SUM_W       = 40;
   localparam int CNT_W       = 24;
   localparam int FOCAL_W     = 16;
   localparam int FB_W        = 32;
   localparam int CENTRE_W    = 16;
   localparam int POS_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MAG_W       = ROI_W + 4;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DVD_W       = FB_W + CNT_W + DISP_FRAC;
   localparam int DVS_W       = SUM_W;
   localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

   // floor(t/5) as (t * ceil(2^20/5)) >> 20, exact for t below 2^18
   localparam int RECIP5_SH   = 20;
   localparam int DIV5_P_W    = COORD_W + RECIP5_SH + 1;
   localparam logic [17:0] RECIP5 = 18'd209716;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Register reset values
   localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 16'd36200;
   localparam logic [FB_W-1:0]     FB_RST       = 32'd30989812;
   localparam logic [CENTRE_W-1:0] CENTRE_X_RST = 16'd17552;
   localparam logic [CENTRE_W-1:0] CENTRE_Y_RST = 16'd8210;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y = 2'd3;

   typedef enum logic [1:0] {
      AXIS_Z = 2'd0,
      AXIS_X = 2'd1,
      AXIS_Y = 2'd2
   } axis_type;

   typedef struct packed {
      logic     load_box;
      logic     accum;
      logic     check;
      logic     mul_en;
      logic     div_start;
      logic     latch;
      axis_type axis;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic div_busy;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/sbt_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbt_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic        [sbt_pkg::COORD_W-1:0]  box_x;
   logic        [sbt_pkg::COORD_W-1:0]  box_y;
   logic        [sbt_pkg::COORD_W-1:0]  box_w;
   logic        [sbt_pkg::COORD_W-1:0]  box_h;
   logic        [sbt_pkg::COORD_W-1:0]  pixel_x;
   logic        [sbt_pkg::COORD_W-1:0]  pixel_y;
   logic signed [sbt_pkg::DISP_W-1:0]   disparity;
   logic                                last;

   modport source (
      output valid, command, box_x, box_y, box_w, box_h,
             pixel_x, pixel_y, disparity, last,
      input  ready
   );

   modport sink (
      input  valid, command, box_x, box_y, box_w, box_h,
             pixel_x, pixel_y, disparity, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/sbt_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              located;
   logic signed [sbt_pkg::POS_W-1:0]  pos_x;
   logic signed [sbt_pkg::POS_W-1:0]  pos_y;
   logic        [sbt_pkg::POS_W-1:0]  pos_z;

   modport source (
      output valid, located, pos_x, pos_y, pos_z,
      input  ready
   );

   modport sink (
      input  valid, located, pos_x, pos_y, pos_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/stereo_box_triangulation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Beat carries
// req_chan   in   command, box_x/y/w/h, pixel_x/y, disparity, last
// rsp_chan   out  located, pos_x, pos_y, pos_z
// csr_*      in   write enable, register index, 32-bit write data
//
// A box beat or a pixel beat without last is accepted in the idle state; pixels stream at one per cycle while idle.
// After a pixel beat with last, the result is computed and then registered: the
// shared 60-step restoring divider runs three times (depth, then lateral, then vertical).
// With no counted pixel the divider is skipped and the check state goes straight to the push.
// Synchronous active-high reset restores the register defaults and empties the region.
// A waiting result sits in its own register; the next result holds in the push state until it drains.
module stereo_box_triangulation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sbt_req_if.sink                                  req_chan,
   sbt_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic        [sbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [sbt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sbt_pkg::cmd_type    cmd;
   sbt_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;

   // Sequencer: accepts beats, steps the triangulation, owns the result valid
   sbt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid_i    (req_chan.valid),
      .req_is_pixel_i (req_chan.command),
      .req_last_i     (req_chan.last),
      .req_ready_o    (req_ready),
      .rsp_valid_o    (rsp_valid),
      .rsp_ready_i    (rsp_chan.ready),
      .status_i       (status),
      .cmd_o          (cmd)
   );

   // Region, accumulators, shared multiplier and divider, result register
   sbt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .status_o     (status),
      .csr_we_i     (csr_we),
      .csr_index_i  (csr_index),
      .csr_wdata_i  (csr_wdata),
      .box_x_i      (req_chan.box_x),
      .box_y_i      (req_chan.box_y),
      .box_w_i      (req_chan.box_w),
      .box_h_i      (req_chan.box_h),
      .pixel_x_i    (req_chan.pixel_x),
      .pixel_y_i    (req_chan.pixel_y),
      .disparity_i  (req_chan.disparity),
      .located_o    (rsp_chan.located),
      .pos_x_o      (rsp_chan.pos_x),
      .pos_y_o      (rsp_chan.pos_y),
      .pos_z_o      (rsp_chan.pos_z)
   );

   // Drive the handshake lines of both channels
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

// ===== rtl/sbt_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sbt_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start_i,
   input  wire logic [sbt_pkg::DVD_W-1:0]     dividend_i,
   input  wire logic [sbt_pkg::DVS_W-1:0]     divisor_i,
   output logic                               busy_o,
   output logic                               done_o,
   output logic      [sbt_pkg::DVD_W-1:0]     quotient_o
);

   logic [sbt_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [sbt_pkg::DVD_W-1:0]     quo_ff, quo_in;
   logic [sbt_pkg::DVS_W-1:0]     dvs_ff, dvs_in;
   logic [sbt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [sbt_pkg::DVS_W:0]       shifted;
   logic [sbt_pkg::DVS_W:0]       diff;
   logic                          fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[sbt_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = ~diff[sbt_pkg::DVS_W];

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start_i) begin
         rem_in  = '0;
         quo_in  = dividend_i;
         dvs_in  = divisor_i;
         cnt_in  = sbt_pkg::DIV_CNT_W'(sbt_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[sbt_pkg::DVS_W-1:0] : shifted[sbt_pkg::DVS_W-1:0];
         quo_in = {quo_ff[sbt_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == sbt_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy_o     = busy_ff;
   assign done_o     = done_ff;
   assign quotient_o = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> !busy_ff)
      else $error("divider started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start_i && cnt_ff == sbt_pkg::DIV_CNT_W'(1)) |=> (done_ff && !busy_ff))
      else $error("divider final step did not finish");

endmodule

`default_nettype wire

// ===== rtl/sbt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sbt_pkg::cmd_type                    cmd_i,
   output sbt_pkg::status_type                      status_o,
   input  wire logic                                csr_we_i,
   input  wire logic        [sbt_pkg::CSR_IDX_W-1:0]  csr_index_i,
   input  wire logic        [sbt_pkg::CSR_DATA_W-1:0] csr_wdata_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  box_x_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  box_y_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  box_w_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  box_h_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  pixel_x_i,
   input  wire logic        [sbt_pkg::COORD_W-1:0]  pixel_y_i,
   input  wire logic signed [sbt_pkg::DISP_W-1:0]   disparity_i,
   output logic                                     located_o,
   output logic signed      [sbt_pkg::POS_W-1:0]    pos_x_o,
   output logic signed      [sbt_pkg::POS_W-1:0]    pos_y_o,
   output logic             [sbt_pkg::POS_W-1:0]    pos_z_o
);

   // floor(t/5) by reciprocal multiply
   function automatic logic [sbt_pkg::COORD_W-1:0] div5(
      input logic [sbt_pkg::COORD_W:0] t
   );
      logic [sbt_pkg::DIV5_P_W-1:0] p;
      p = sbt_pkg::DIV5_P_W'(t) * sbt_pkg::DIV5_P_W'(sbt_pkg::RECIP5);
      return p[sbt_pkg::RECIP5_SH +: sbt_pkg::COORD_W];
   endfunction

   // floor(0.35 v) = floor(floor(7v/4)/5)
   function automatic logic [sbt_pkg::COORD_W-1:0] frac35(
      input logic [sbt_pkg::COORD_W-1:0] v
   );
      logic [sbt_pkg::COORD_W+2:0] n7;
      n7 = ({3'b000, v} << 3) - {3'b000, v};
      return div5(n7[sbt_pkg::COORD_W+2:2]);
   endfunction

   // floor(0.3 v) = floor(floor(3v/2)/5)
   function automatic logic [sbt_pkg::COORD_W-1:0] frac30(
      input logic [sbt_pkg::COORD_W-1:0] v
   );
      logic [sbt_pkg::COORD_W+1:0] n3;
      n3 = ({2'b00, v} << 1) + {2'b00, v};
      return div5(n3[sbt_pkg::COORD_W+1:1]);
   endfunction

   // Saturate a lateral quotient to signed 32 bits and apply its sign
   function automatic logic [sbt_pkg::POS_W-1:0] lat_sat(
      input logic [sbt_pkg::DVD_W-1:0] q,
      input logic                      neg
   );
      logic big;
      big = |q[sbt_pkg::DVD_W-1:sbt_pkg::POS_W-1];
      if (neg)
         return big ? {1'b1, {(sbt_pkg::POS_W-1){1'b0}}}
                    : sbt_pkg::POS_W'(0) - q[sbt_pkg::POS_W-1:0];
      else
         return big ? {1'b0, {(sbt_pkg::POS_W-1){1'b1}}} : q[sbt_pkg::POS_W-1:0];
   endfunction

   // Configuration
   logic [sbt_pkg::FOCAL_W-1:0]  focal_ff;
   logic [sbt_pkg::FB_W-1:0]     fb_ff;
   logic [sbt_pkg::CENTRE_W-1:0] cx_ff;
   logic [sbt_pkg::CENTRE_W-1:0] cy_ff;

   // Box geometry and accumulators
   logic [sbt_pkg::ROI_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [sbt_pkg::ROI_W-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [sbt_pkg::ROI_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [sbt_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [sbt_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // Arithmetic
   logic [sbt_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [sbt_pkg::PROD_W-1:0] prod_ff;
   logic                       neg_ff;
   logic [sbt_pkg::MAG_W-1:0]  p16, cref, mag;
   logic                       neg;
   logic [sbt_pkg::DVD_W-1:0]  dividend;
   logic [sbt_pkg::DVS_W-1:0]  divisor;
   logic [sbt_pkg::FOCAL_W-1:0] focal_eff;
   logic [sbt_pkg::DVD_W-1:0]  quotient;
   logic                       div_busy, div_done;

   // Result
   logic                      loc_ff;
   logic [sbt_pkg::POS_W-1:0] z_ff, x_ff, y_ff;
   logic                      rsp_loc_ff;
   logic [sbt_pkg::POS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [sbt_pkg::ROI_W-1:0] px, py;
   logic                      in_region, positive;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= sbt_pkg::FOCAL_RST;
         fb_ff    <= sbt_pkg::FB_RST;
         cx_ff    <= sbt_pkg::CENTRE_X_RST;
         cy_ff    <= sbt_pkg::CENTRE_Y_RST;
      end else if (csr_we_i) begin
         case (csr_index_i)
            sbt_pkg::CSR_FOCAL:    focal_ff <= csr_wdata_i[sbt_pkg::FOCAL_W-1:0];
            sbt_pkg::CSR_FB:       fb_ff    <= csr_wdata_i[sbt_pkg::FB_W-1:0];
            sbt_pkg::CSR_CENTRE_X: cx_ff    <= csr_wdata_i[sbt_pkg::CENTRE_W-1:0];
            sbt_pkg::CSR_CENTRE_Y: cy_ff    <= csr_wdata_i[sbt_pkg::CENTRE_W-1:0];
            default: ;
         endcase
      end
   end

   // Region test and accumulation
   always_comb begin
      px        = {1'b0, pixel_x_i};
      py        = {1'b0, pixel_y_i};
      in_region = (px >= left_ff) && (px < right_ff) && (py >= top_ff) && (py < bottom_ff);
      positive  = !disparity_i[sbt_pkg::DISP_W-1] && (|disparity_i);

      left_in   = left_ff;
      right_in  = right_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;

      if (cmd_i.load_box) begin
         left_in   = {1'b0, box_x_i} + {1'b0, frac35(box_w_i)};
         right_in  = left_in + {1'b0, frac30(box_w_i)};
         top_in    = {1'b0, box_y_i} + {1'b0, frac35(box_h_i)};
         bottom_in = top_in + {1'b0, frac30(box_h_i)};
         col_in    = {1'b0, box_x_i} + {2'b00, box_w_i[sbt_pkg::COORD_W-1:1]};
         row_in    = {1'b0, box_y_i} + {1'b0, box_h_i};
         sum_in    = '0;
         cnt_in    = '0;
      end else if (cmd_i.accum && positive && in_region && cnt_ff != sbt_pkg::CNT_MAX) begin
         sum_in = sum_ff + sbt_pkg::SUM_W'(unsigned'(disparity_i));
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Operand selection for the shared multiplier and divider
   always_comb begin
      if (cmd_i.axis == sbt_pkg::AXIS_Y) begin
         p16  = {row_ff, 4'b0000};
         cref = sbt_pkg::MAG_W'(cy_ff);
      end else begin
         p16  = {col_ff, 4'b0000};
         cref = sbt_pkg::MAG_W'(cx_ff);
      end
      neg = p16 < cref;
      mag = neg ? cref - p16 : p16 - cref;

      focal_eff = (focal_ff == '0) ? sbt_pkg::FOCAL_W'(1) : focal_ff;

      case (cmd_i.axis)
         sbt_pkg::AXIS_Z: begin
            mul_a    = fb_ff;
            mul_b    = sbt_pkg::MUL_W'(cnt_ff);
            dividend = sbt_pkg::DVD_W'(prod_ff) << sbt_pkg::DISP_FRAC;
            divisor  = sum_ff;
         end
         default: begin
            mul_a    = z_ff;
            mul_b    = sbt_pkg::MUL_W'(mag);
            dividend = sbt_pkg::DVD_W'(prod_ff);
            divisor  = sbt_pkg::DVS_W'(focal_eff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_i.mul_en) begin
         prod_ff <= sbt_pkg::PROD_W'(mul_a) * sbt_pkg::PROD_W'(mul_b);
         neg_ff  <= neg;
      end
   end

   sbt_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (cmd_i.div_start),
      .dividend_i (dividend),
      .divisor_i  (divisor),
      .busy_o     (div_busy),
      .done_o     (div_done),
      .quotient_o (quotient)
   );

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd_i.check) begin
         loc_ff <= !((cnt_ff == '0) || (sum_ff == '0));
         z_ff   <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
      end else if (cmd_i.latch) begin
         case (cmd_i.axis)
            sbt_pkg::AXIS_Z:
               z_ff <= (|quotient[sbt_pkg::DVD_W-1:sbt_pkg::POS_W]) ?
                       {sbt_pkg::POS_W{1'b1}} : quotient[sbt_pkg::POS_W-1:0];
            sbt_pkg::AXIS_X: x_ff <= lat_sat(quotient, neg_ff);
            sbt_pkg::AXIS_Y: y_ff <= lat_sat(quotient, neg_ff);
            default: ;
         endcase
      end
      if (cmd_i.load_rsp) begin
         rsp_loc_ff <= loc_ff;
         rsp_x_ff   <= x_ff;
         rsp_y_ff   <= y_ff;
         rsp_z_ff   <= z_ff;
      end
   end

   assign status_o.empty    = (cnt_ff == '0) || (sum_ff == '0);
   assign status_o.div_busy = div_busy;
   assign status_o.div_done = div_done;

   assign located_o = rsp_loc_ff;
   assign pos_x_o   = signed'(rsp_x_ff);
   assign pos_y_o   = signed'(rsp_y_ff);
   assign pos_z_o   = rsp_z_ff;

endmodule

`default_nettype wire

// ===== rtl/sbt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid_i,
   input  wire logic                 req_is_pixel_i,
   input  wire logic                 req_last_i,
   output logic                      req_ready_o,
   output logic                      rsp_valid_o,
   input  wire logic                 rsp_ready_i,
   input  wire sbt_pkg::status_type  status_i,
   output sbt_pkg::cmd_type          cmd_o
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CHECK   = 6'b000010,
      S_MUL     = 6'b000100,
      S_DIVGO   = 6'b001000,
      S_DIVWAIT = 6'b010000,
      S_PUSH    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   sbt_pkg::axis_type  axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cmd_o        = '0;
      cmd_o.axis   = axis_ff;
      req_ready_o  = 1'b0;
      accept       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready_o = 1'b1;
            accept      = req_valid_i;
            if (req_valid_i) begin
               if (!req_is_pixel_i) begin
                  cmd_o.load_box = 1'b1;
               end else begin
                  cmd_o.accum = 1'b1;
                  if (req_last_i)
                     state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            cmd_o.check = 1'b1;
            axis_in     = sbt_pkg::AXIS_Z;
            state_in    = status_i.empty ? S_PUSH : S_MUL;
         end
         S_MUL: begin
            cmd_o.mul_en = 1'b1;
            state_in     = S_DIVGO;
         end
         S_DIVGO: begin
            cmd_o.div_start = 1'b1;
            state_in        = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (status_i.div_done) begin
               cmd_o.latch = 1'b1;
               case (axis_ff)
                  sbt_pkg::AXIS_Z: begin
                     axis_in  = sbt_pkg::AXIS_X;
                     state_in = S_MUL;
                  end
                  sbt_pkg::AXIS_X: begin
                     axis_in  = sbt_pkg::AXIS_Y;
                     state_in = S_MUL;
                  end
                  default: state_in = S_PUSH;
               endcase
            end
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp_ready_i) begin
               cmd_o.load_rsp = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd_o.load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_ready_i)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= sbt_pkg::AXIS_Z;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_o = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.load_rsp |-> (!rsp_valid_ff || rsp_ready_i))
      else $error("result register overwritten before it was taken");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_pixel_i && req_last_i) |=> (state_ff == S_CHECK))
      else $error("final pixel did not start the result computation");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_o.div_start |-> !status_i.div_busy)
      else $error("division requested while the divider is busy");

endmodule

`default_nettype wire
